FILE: hdl/dual_stepper_ramp_pulser_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dual stepper ramp pulser
// Shared property wrappers clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef DUAL_STEPPER_RAMP_PULSER_DEFINES_SVH
`define DUAL_STEPPER_RAMP_PULSER_DEFINES_SVH

// same-cycle implication
`define DSRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsrp: implication check failed");

// next-cycle implication
`define DSRP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsrp: next-cycle check failed");

`endif

FILE: hdl/dsrp_pkg.sv
// ---------------------------------------------------------------------------
// dsrp_pkg
// Shared types, codes and reset constants of the dual stepper ramp pulser.
// ---------------------------------------------------------------------------
`default_nettype none

package dsrp_pkg;

  localparam logic [7:0]  START_PERIOD_RST   = 8'd43;
  localparam logic [15:0] ACCEL_TICKS_RST    = 16'd1975;
  localparam logic [15:0] DECEL_TICKS_RST    = 16'd1053;
  localparam logic [15:0] RETARGET_TICKS_RST = 16'd2107;
  localparam logic [7:0]  TARGET_RST         = 8'd16;

  // command codes; the top three are unused and do nothing
  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_START   = 3'd1,
    MODE_STOP    = 3'd2,
    MODE_TGT_ONE = 3'd3,
    MODE_TGT_TWO = 3'd4,
    MODE_RSVD5   = 3'd5,
    MODE_RSVD6   = 3'd6,
    MODE_RSVD7   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    REG_START_PERIOD = 2'd0,
    REG_ACCEL_TICKS  = 2'd1,
    REG_DECEL_TICKS  = 2'd2,
    REG_RETARGET     = 2'd3
  } reg_idx_e;

  // drive from the ramp sequencer to the pulse counters
  typedef struct packed {
    logic [7:0] period_one;
    logic [7:0] period_two;
    logic       advance;
  } drive_t;

  // flag values after the current transfer
  typedef struct packed {
    logic [1:0] settled;
    logic [1:0] enable;
    logic       busy;
    logic       running;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/dsrp_pulse.sv
// ---------------------------------------------------------------------------
// dsrp_pulse
// One step channel: 8-bit wrapping counter compared against the half-period.
// ---------------------------------------------------------------------------
`default_nettype none

module dsrp_pulse (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic [7:0] period_i,
  output logic            level_nxt_o
);

  `include "dual_stepper_ramp_pulser_defines.svh"

  logic [7:0] count_q, count_d, count_inc;
  logic       level_q, level_d;

  always_comb begin
    count_inc = count_q + 8'd1;
    count_d   = count_q;
    level_d   = level_q;
    if (adv_i) begin
      if (count_inc >= period_i) begin
        level_d = ~level_q;
        count_d = count_inc - period_i;
      end else begin
        count_d = count_inc;
      end
    end
  end

  assign level_nxt_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
    end else begin
      count_q <= count_d;
      level_q <= level_d;
    end
  end

  `DSRP_ASSERT_NXT(a_level_holds, !adv_i, $stable(level_q))
  `DSRP_ASSERT_NXT(a_count_holds, !adv_i, $stable(count_q))
  `DSRP_ASSERT_IMP(a_count_below, adv_i && period_i != 8'd0 && count_q < period_i,
                   count_d < period_i)

endmodule

`default_nettype wire

FILE: hdl/dsrp_ramp.sv
// ---------------------------------------------------------------------------
// dsrp_ramp
// Command decode, ramp sequencer, period/target state and config registers.
// ---------------------------------------------------------------------------
`default_nettype none

module dsrp_ramp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [2:0]   mode_i,
  input  wire logic [7:0]   value_i,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i,
  output dsrp_pkg::drive_t  drive_o,
  output dsrp_pkg::status_t status_o
);

  `include "dual_stepper_ramp_pulser_defines.svh"

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_ACCEL  = 5'b00010,
    PH_DECEL  = 5'b00100,
    PH_RT_ONE = 5'b01000,
    PH_RT_TWO = 5'b10000
  } phase_e;

  logic [7:0]  start_period_q;
  logic [15:0] accel_ticks_q, decel_ticks_q, retarget_ticks_q;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  p1_q, p1_d, p2_q, p2_d, t1_q, t1_d, t2_q, t2_d;
  logic [1:0]  settled_q, settled_d, enable_q, enable_d;
  logic        run_q, run_d;
  logic        do_accel, do_decel;
  logic        is_tick;

  assign is_tick = (mode_i == dsrp_pkg::MODE_TICK);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    settled_d = settled_q;
    enable_d  = enable_q;
    run_d     = run_q;
    do_accel  = 1'b0;
    do_decel  = 1'b0;

    if (accept_i) begin
      if (is_tick) begin
        if (phase_q != PH_IDLE) begin
          if (cnt_q > 16'd1) begin
            cnt_d = cnt_q - 16'd1;
          end else begin
            cnt_d = '0;
            case (phase_q)
              PH_ACCEL: do_accel = 1'b1;
              PH_DECEL: do_decel = 1'b1;
              PH_RT_ONE: begin
                if (p1_q < t1_q)      p1_d = p1_q + 8'd1;
                else if (p1_q > t1_q) p1_d = p1_q - 8'd1;
                if (p1_d == t1_q) begin
                  settled_d[0] = 1'b1;
                  phase_d      = PH_IDLE;
                end else begin
                  cnt_d = retarget_ticks_q;
                end
              end
              PH_RT_TWO: begin
                if (p2_q < t2_q)      p2_d = p2_q + 8'd1;
                else if (p2_q > t2_q) p2_d = p2_q - 8'd1;
                if (p2_d == t2_q) begin
                  settled_d[1] = 1'b1;
                  phase_d      = PH_IDLE;
                end else begin
                  cnt_d = retarget_ticks_q;
                end
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        end
      end else if (phase_q == PH_IDLE) begin
        case (mode_i)
          dsrp_pkg::MODE_START: begin
            p1_d      = start_period_q;
            p2_d      = start_period_q;
            run_d     = 1'b1;
            enable_d  = 2'b11;
            settled_d = 2'b00;
            do_accel  = 1'b1;
          end
          dsrp_pkg::MODE_STOP: begin
            settled_d = 2'b00;
            do_decel  = 1'b1;
          end
          dsrp_pkg::MODE_TGT_ONE: begin
            if (value_i != 8'd0) begin
              t1_d = value_i;
              if (p1_q == value_i) begin
                settled_d[0] = 1'b1;
              end else begin
                settled_d[0] = 1'b0;
                cnt_d        = retarget_ticks_q;
                phase_d      = PH_RT_ONE;
              end
            end
          end
          dsrp_pkg::MODE_TGT_TWO: begin
            if (value_i != 8'd0) begin
              t2_d = value_i;
              if (p2_q == value_i) begin
                settled_d[1] = 1'b1;
              end else begin
                settled_d[1] = 1'b0;
                cnt_d        = retarget_ticks_q;
                phase_d      = PH_RT_TWO;
              end
            end
          end
          default: ;
        endcase
      end
    end

    // one step of the start ramp, on the periods chosen above
    if (do_accel) begin
      if (p1_d > t1_q || p2_d > t2_q) begin
        if (p1_d > t1_q) p1_d = p1_d - 8'd1; else settled_d[0] = 1'b1;
        if (p2_d > t2_q) p2_d = p2_d - 8'd1; else settled_d[1] = 1'b1;
        cnt_d   = accel_ticks_q;
        phase_d = PH_ACCEL;
      end else begin
        p1_d      = t1_q;
        p2_d      = t2_q;
        settled_d = 2'b11;
        phase_d   = PH_IDLE;
      end
    end

    // one step of the stop ramp
    if (do_decel) begin
      if (p1_d < start_period_q || p2_d < start_period_q) begin
        if (p1_d < start_period_q) begin
          p1_d = p1_d + 8'd1;
        end else begin
          settled_d[0] = 1'b1;
          enable_d[0]  = 1'b0;
        end
        if (p2_d < start_period_q) begin
          p2_d = p2_d + 8'd1;
        end else begin
          settled_d[1] = 1'b1;
          enable_d[1]  = 1'b0;
        end
        cnt_d   = decel_ticks_q;
        phase_d = PH_DECEL;
      end else begin
        settled_d = 2'b11;
        enable_d  = 2'b00;
        run_d     = 1'b0;
        phase_d   = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      p1_q      <= '0;
      p2_q      <= '0;
      t1_q      <= dsrp_pkg::TARGET_RST;
      t2_q      <= dsrp_pkg::TARGET_RST;
      settled_q <= '0;
      enable_q  <= '0;
      run_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      t1_q      <= t1_d;
      t2_q      <= t2_d;
      settled_q <= settled_d;
      enable_q  <= enable_d;
      run_q     <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_period_q   <= dsrp_pkg::START_PERIOD_RST;
      accel_ticks_q    <= dsrp_pkg::ACCEL_TICKS_RST;
      decel_ticks_q    <= dsrp_pkg::DECEL_TICKS_RST;
      retarget_ticks_q <= dsrp_pkg::RETARGET_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsrp_pkg::REG_START_PERIOD: start_period_q   <= cfg_data_i[7:0];
        dsrp_pkg::REG_ACCEL_TICKS:  accel_ticks_q    <= cfg_data_i;
        dsrp_pkg::REG_DECEL_TICKS:  decel_ticks_q    <= cfg_data_i;
        dsrp_pkg::REG_RETARGET:     retarget_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counters run on the periods held before this transfer
  assign drive_o.period_one = p1_q;
  assign drive_o.period_two = p2_q;
  assign drive_o.advance    = accept_i && is_tick && run_q;

  assign status_o.settled = settled_d;
  assign status_o.enable  = enable_d;
  assign status_o.busy    = (phase_d != PH_IDLE);
  assign status_o.running = run_d;

  `DSRP_ASSERT_IMP(a_enable_needs_run, enable_q != 2'b00, run_q)
  `DSRP_ASSERT_NXT(a_busy_ignores_cmd, accept_i && !is_tick && phase_q != PH_IDLE,
                   $stable(p1_q) && $stable(p2_q) && $stable(t1_q) && $stable(t2_q))
  `DSRP_ASSERT_IMP(a_idle_count_zero_ok, phase_q == PH_IDLE && accept_i && is_tick,
                   phase_d == PH_IDLE)

endmodule

`default_nettype wire

FILE: hdl/dual_stepper_ramp_pulser.sv
// ---------------------------------------------------------------------------
// dual_stepper_ramp_pulser
// Two-channel stepper pulse generator with start, stop and retarget ramps.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries commands: tuser = mode (tick, start, stop, set
//   target one/two), tdata = value. Every accepted transfer yields exactly
//   one master transfer holding the step levels and status flags as they
//   stand after that command.
//   Config port writes start_period, accel_ticks, decel_ticks and
//   retarget_ticks at any edge with cfg_we_i high; write only while idle.
//   Latency: the result is valid the cycle after the input transfer.
//   Throughput: one command per cycle; the single pass of compare and
//   counter update between the command and the result register sets this.
//   A stalled master side holds the result; the slave side keeps taking
//   commands only while the result register is empty or being drained.
//   Reset: periods and counters clear, targets return to 16, config
//   registers to their defaults, no result pending.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_stepper_ramp_pulser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] value
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] step_one [1] step_two [2] settled_one [3] settled_two
  // [4] enable_one [5] enable_two [6] busy_res [7] running
  output logic [7:0]       m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  `include "dual_stepper_ramp_pulser_defines.svh"

  logic              accept;
  logic              lvl_one, lvl_two;
  logic              m_valid_q;
  logic [7:0]        m_data_q;
  dsrp_pkg::drive_t  drive;
  dsrp_pkg::status_t status;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dsrp_ramp u_ramp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .mode_i     (s_axis_tuser),
    .value_i    (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .drive_o    (drive),
    .status_o   (status)
  );

  dsrp_pulse u_pulse_one (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (drive.advance),
    .period_i    (drive.period_one),
    .level_nxt_o (lvl_one)
  );

  dsrp_pulse u_pulse_two (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (drive.advance),
    .period_i    (drive.period_two),
    .level_nxt_o (lvl_two)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= {status.running, status.busy, status.enable, status.settled,
                   lvl_two, lvl_one};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `DSRP_ASSERT_NXT(a_accept_fills, accept, m_valid_q)
  `DSRP_ASSERT_NXT(a_result_kept, m_valid_q && !m_axis_tready, $stable(m_data_q))
  `DSRP_ASSERT_IMP(a_no_advance_idle, !accept, !drive.advance)

endmodule

`default_nettype wire
